// ----- rtl/csc_pkg.sv -----
package csc_pkg;

  // Number of micro-rotations built into the pipeline.
  localparam int MAX_ITERATIONS = 16;

  // Field widths.
  localparam int ANGLE_W = 15;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 5;

  // Internal datapath: signed, LSB of 2^-20, enough headroom for +-4.
  localparam int DATA_W      = 24;
  localparam int ANGLE_SHIFT = 7;
  localparam int OUT_SHIFT   = 6;
  localparam int OUT_LIMIT   = 16384;
  localparam int GAIN_FX     = 636751;

  localparam int ROM_IDX_W = 5;
  localparam int IDX_W     = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITERATIONS + 1);

  localparam logic [CFG_W-1:0] ITER_RESET = CFG_W'(16);

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic [CNT_W-1:0]         n;
  } csc_data_t;

  // atan(2^-i) scaled by 2^20, rounded to nearest.
  function automatic logic signed [DATA_W-1:0] atan_rom(input logic [ROM_IDX_W-1:0] i);
    logic signed [DATA_W-1:0] v;
    case (i)
      5'd0:    v = DATA_W'(823550);
      5'd1:    v = DATA_W'(486170);
      5'd2:    v = DATA_W'(256879);
      5'd3:    v = DATA_W'(130396);
      5'd4:    v = DATA_W'(65451);
      5'd5:    v = DATA_W'(32757);
      5'd6:    v = DATA_W'(16383);
      5'd7:    v = DATA_W'(8192);
      5'd8:    v = DATA_W'(4096);
      5'd9:    v = DATA_W'(2048);
      5'd10:   v = DATA_W'(1024);
      5'd11:   v = DATA_W'(512);
      5'd12:   v = DATA_W'(256);
      5'd13:   v = DATA_W'(128);
      5'd14:   v = DATA_W'(64);
      5'd15:   v = DATA_W'(32);
      5'd16:   v = DATA_W'(16);
      5'd17:   v = DATA_W'(8);
      5'd18:   v = DATA_W'(4);
      5'd19:   v = DATA_W'(2);
      5'd20:   v = DATA_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/csc_stage.sv -----
module csc_stage
  import csc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] index,
  input  logic             up_valid,
  input  csc_data_t        up_data,
  output logic             up_ready,
  output logic             down_valid,
  output csc_data_t        down_data,
  input  logic             down_ready
);

  logic      valid;
  csc_data_t data;
  csc_data_t data_next;
  logic      active;
  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  logic signed [DATA_W-1:0] rom;

  assign up_ready = !valid || down_ready;
  assign active   = {{(CNT_W - IDX_W){1'b0}}, index} < up_data.n;
  assign xs       = up_data.x >>> index;
  assign ys       = up_data.y >>> index;
  assign rom      = atan_rom(ROM_IDX_W'(index));

  // One micro-rotation; stages past the requested count pass the item through.
  always_comb begin
    data_next = up_data;
    if (active) begin
      if (!up_data.z[DATA_W-1]) begin
        data_next.x = up_data.x - ys;
        data_next.y = up_data.y + xs;
        data_next.z = up_data.z - rom;
      end else begin
        data_next.x = up_data.x + ys;
        data_next.y = up_data.y - xs;
        data_next.z = up_data.z + rom;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    valid && !down_ready |=> valid && $stable(data))
    else $error("stage lost or changed a stalled item");

  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    up_valid && up_ready |=> valid)
    else $error("stage dropped an accepted item");

endmodule

// ----- rtl/csc_round.sv -----
module csc_round
  import csc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  input  csc_data_t               up_data,
  output logic                    up_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] sine,
  output logic signed [OUT_W-1:0] cosine
);

  logic                    valid;
  logic signed [OUT_W-1:0] sine_q;
  logic signed [OUT_W-1:0] cosine_q;

  // Round half up to Q1.14, then clamp to plus or minus one.
  function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    logic signed [OUT_W-1:0]  q;
    r = (v + DATA_W'(1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > DATA_W'(OUT_LIMIT)) begin
      q = OUT_W'(OUT_LIMIT);
    end else if (r < -DATA_W'(OUT_LIMIT)) begin
      q = -OUT_W'(OUT_LIMIT);
    end else begin
      q = r[OUT_W-1:0];
    end
    return q;
  endfunction

  assign up_ready = !valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sine_q   <= to_q14(up_data.y);
      cosine_q <= to_q14(up_data.x);
    end
  end

  assign out_valid = valid;
  assign sine      = sine_q;
  assign cosine    = cosine_q;

  a_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> sine_q <= OUT_W'(OUT_LIMIT) && sine_q >= -OUT_W'(OUT_LIMIT)
           && cosine_q <= OUT_W'(OUT_LIMIT) && cosine_q >= -OUT_W'(OUT_LIMIT))
    else $error("result outside plus or minus one");

endmodule

// ----- rtl/cordic_sine_cosine.sv -----
// Sine and cosine of one angle by rotation-mode CORDIC.
// Input channel: angle (signed Q2.13 radians, meant for plus or minus pi/2)
// with in_valid and in_stall; a request is taken when in_valid is high and
// in_stall is low. Output channel: sine and cosine (signed Q1.14, clamped to
// plus or minus one) with out_valid and out_stall, same rule.
// Configuration: cfg_valid/cfg_ready/cfg_data writes iteration_count (1 to 16
// micro-rotations, larger values act as 16, zero gives sine 0 and cosine
// 9949). cfg_ready is always high; write it only while no request is in flight.
// A request passes one entry register, one register per micro-rotation and one
// rounding register. The count only decides which stages rotate, so latency
// does not depend on it. Throughput is one request per cycle while out_stall is
// low: every micro-rotation has its own stage.
// When the receiver stalls, items close up behind the output register with
// nothing lost; in_stall rises only once every stage holds an item.
// Reset (rst, synchronous) empties the pipeline and sets iteration_count to 16.
module cordic_sine_cosine
  import csc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   sine,
  output logic signed [OUT_W-1:0]   cosine,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          cfg_data
);

  logic [CFG_W-1:0] iteration_count;
  logic [CNT_W-1:0] count_sat;

  // Link k runs from stage k-1 (link 0: entry) to stage k (link 16: rounding).
  logic      link_valid [0:MAX_ITERATIONS];
  csc_data_t link_data  [0:MAX_ITERATIONS];
  logic      link_ready [0:MAX_ITERATIONS];

  logic      entry_valid;
  csc_data_t entry_data;
  logic      entry_ready;

  // The register has no side effects, so writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iteration_count <= cfg_data;
    end
  end

  // Counts past the pipeline depth run every stage.
  assign count_sat = (32'(iteration_count) > MAX_ITERATIONS) ? CNT_W'(MAX_ITERATIONS)
                                                               : CNT_W'(iteration_count);

  assign entry_ready = !entry_valid || link_ready[0];
  assign in_stall    = !entry_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (entry_ready) begin
      entry_valid <= in_valid;
    end
  end

  // x starts at the inverse CORDIC gain, y at zero, the residual at the angle.
  always_ff @(posedge clk) begin
    if (entry_ready && in_valid) begin
      entry_data.x <= DATA_W'(GAIN_FX);
      entry_data.y <= '0;
      entry_data.z <= DATA_W'(angle) <<< ANGLE_SHIFT;
      entry_data.n <= count_sat;
    end
  end

  assign link_valid[0] = entry_valid;
  assign link_data[0]  = entry_data;

  for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_stage
    csc_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .index      (IDX_W'(k)),
      .up_valid   (link_valid[k]),
      .up_data    (link_data[k]),
      .up_ready   (link_ready[k]),
      .down_valid (link_valid[k+1]),
      .down_data  (link_data[k+1]),
      .down_ready (link_ready[k+1])
    );
  end

  csc_round u_round (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (link_valid[MAX_ITERATIONS]),
    .up_data   (link_data[MAX_ITERATIONS]),
    .up_ready  (link_ready[MAX_ITERATIONS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sine      (sine),
    .cosine    (cosine)
  );

  a_cfg_reset: assert property (@(posedge clk)
    rst |=> iteration_count == ITER_RESET)
    else $error("iteration count not restored by reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> entry_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline had room");

endmodule
